[hdl/audio_tail_fade_out_assert.svh]
// Assertion macros shared by the fade-out RTL.
`ifndef AUDIO_TAIL_FADE_OUT_ASSERT_SVH
`define AUDIO_TAIL_FADE_OUT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ATFO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fade-out assertion failed");

// next-cycle implication, disabled in reset
`define ATFO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fade-out assertion failed");

`endif

[hdl/atfo_pkg.sv]
// Shared constants and types of the tail fade-out pipeline.
package atfo_pkg;

    localparam int CHUNK_WORDS = 4096;
    localparam logic [12:0] CHUNK_WORDS_W = 13'(CHUNK_WORDS);

    // quotient is below 2^15, so 15 restoring steps suffice
    localparam int NUM_DIV_STEPS = 15;

    localparam logic CFG_FADE_LIMIT = 1'b0;
    localparam logic CFG_REC_BYTES  = 1'b1;

    typedef struct packed {
        logic [11:0] rem;
        logic [14:0] rest;
        logic [11:0] frames;
        logic [15:0] raw;
        logic        ramp;
    } t_div;

endpackage

[hdl/atfo_front.sv]
// Front stages: fade window decode, then magnitude times weight.
module atfo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [12:0]        i_fade_limit,
    input  logic [31:0]        i_rec_bytes,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [11:0]        i_word_index,
    input  logic [12:0]        i_valid_words,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output atfo_pkg::t_div     o_data
);

    logic [15:0] raw;
    logic [12:0] valid_sat;
    logic [12:0] fade_a;
    logic [28:0] rec_words_q;
    logic [12:0] fade;
    logic [11:0] frames;
    logic [12:0] start;
    logic [12:0] idx13;
    logic [12:0] rel;
    logic [11:0] weight;
    logic        ramp;

    logic        r_a_valid;
    logic [15:0] r_a_mag;
    logic [10:0] r_a_w;
    logic [11:0] r_a_frames;
    logic [15:0] r_a_raw;
    logic        r_a_ramp;
    logic        a_ready;

    logic           r_b_valid;
    atfo_pkg::t_div r_b_data;
    atfo_pkg::t_div n_b_data;
    logic           b_ready;
    logic [26:0]    prod;

    assign raw         = $unsigned(i_sample);
    assign valid_sat   = (i_valid_words > atfo_pkg::CHUNK_WORDS_W) ?
                         atfo_pkg::CHUNK_WORDS_W : i_valid_words;
    assign fade_a      = (valid_sat < i_fade_limit) ? valid_sat : i_fade_limit;
    assign rec_words_q = i_rec_bytes[31:3];
    assign fade        = (rec_words_q < {16'd0, fade_a}) ? rec_words_q[12:0] : fade_a;
    assign frames      = fade[12:1];
    assign start       = valid_sat - fade;
    assign idx13       = {1'b0, i_word_index};
    assign rel         = idx13 - start;
    assign weight      = frames - 12'd1 - rel[12:1];
    assign ramp        = (fade >= 13'd2) && (idx13 < atfo_pkg::CHUNK_WORDS_W) &&
                         (idx13 < valid_sat) && (idx13 >= start) &&
                         (rel < {frames, 1'b0});

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && a_ready) begin
            r_a_mag    <= raw[15] ? 16'(~raw + 16'd1) : raw;
            r_a_w      <= weight[10:0];
            r_a_frames <= frames;
            r_a_raw    <= raw;
            r_a_ramp   <= ramp;
        end
        if (r_a_valid && b_ready) begin
            r_b_data <= n_b_data;
        end
    end

    assign prod = 27'(r_a_mag) * 27'(r_a_w);

    always_comb begin
        n_b_data.rem    = prod[26:15];
        n_b_data.rest   = prod[14:0];
        n_b_data.frames = r_a_frames;
        n_b_data.raw    = r_a_raw;
        n_b_data.ramp   = r_a_ramp;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

[hdl/atfo_div_cell.sv]
// One restoring division step, registered, with its own handshake.
module atfo_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  atfo_pkg::t_div i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output atfo_pkg::t_div o_data
);

    logic           r_valid;
    atfo_pkg::t_div r_data;
    atfo_pkg::t_div n_data;
    logic [12:0]    trial;
    logic [12:0]    diff;
    logic           ge;

    assign o_ready = !r_valid || i_ready;

    assign trial = {i_data.rem, i_data.rest[14]};
    assign diff  = trial - {1'b0, i_data.frames};
    assign ge    = trial >= {1'b0, i_data.frames};

    always_comb begin
        n_data      = i_data;
        n_data.rem  = ge ? diff[11:0] : trial[11:0];
        n_data.rest = {i_data.rest[13:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hdl/atfo_back.sv]
// Output register: restores the sign or passes the word through.
module atfo_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  atfo_pkg::t_div i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_sample,
    output logic           o_ramp
);

    logic        r_valid;
    logic [15:0] r_sample;
    logic        r_ramp;
    logic [15:0] mag;
    logic [15:0] n_sample;

    assign o_ready = !r_valid || i_ready;
    assign mag     = {1'b0, i_data.rest};

    always_comb begin
        if (!i_data.ramp) begin
            n_sample = i_data.raw;
        end else if (i_data.raw[15]) begin
            n_sample = 16'(~mag + 16'd1);
        end else begin
            n_sample = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample <= n_sample;
            r_ramp   <= i_data.ramp;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_ramp   = r_ramp;

endmodule

[hdl/audio_tail_fade_out.sv]
// Top level of the linear tail fade-out: config registers and the cell chain.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: word_index, valid_words, sample_in
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: sample_out; tuser: in_ramp
//  cfg       in   i_cfg_we                         i_cfg_addr, i_cfg_wdata
//
// One request per cycle sustained while the sink keeps i_m_axis_tready high; stages: decode, multiply,
// 15 divider cells (one quotient bit each), output register.
// Every stage has its own valid and ready, so bubbles close up under stall.
// Synchronous active-low reset clears all valids and loads register defaults.
module audio_tail_fade_out (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // word_index[11:0], valid_words[24:12], sample_in[40:25]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // sample_out[15:0]
    output logic [0:0]  o_m_axis_tuser    // in_ramp[0]
);

    `include "audio_tail_fade_out_assert.svh"

    localparam int N = atfo_pkg::NUM_DIV_STEPS;

    logic [12:0] r_fade_limit;
    logic [31:0] r_rec_bytes;

    atfo_pkg::t_div d_chain [0:N];
    logic           v_chain [0:N];
    logic           r_chain [0:N];

    logic [15:0] out_sample;
    logic        out_ramp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_limit <= 13'd960;
            r_rec_bytes  <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                atfo_pkg::CFG_FADE_LIMIT: r_fade_limit <= i_cfg_wdata[12:0];
                atfo_pkg::CFG_REC_BYTES:  r_rec_bytes  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    atfo_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fade_limit (r_fade_limit),
        .i_rec_bytes  (r_rec_bytes),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_word_index (i_s_axis_tdata[11:0]),
        .i_valid_words(i_s_axis_tdata[24:12]),
        .i_sample     ($signed(i_s_axis_tdata[40:25])),
        .o_valid      (v_chain[0]),
        .i_ready      (r_chain[0]),
        .o_data       (d_chain[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        atfo_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(v_chain[k]),
            .o_ready(r_chain[k]),
            .i_data (d_chain[k]),
            .o_valid(v_chain[k+1]),
            .i_ready(r_chain[k+1]),
            .o_data (d_chain[k+1])
        );
    end

    atfo_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_chain[N]),
        .o_ready (r_chain[N]),
        .i_data  (d_chain[N]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sample(out_sample),
        .o_ramp  (out_ramp)
    );

    assign o_m_axis_tdata    = out_sample;
    assign o_m_axis_tuser[0] = out_ramp;

    // stall can only come from a full pipe backed up by the sink
    `ATFO_ASSERT_IMP(a_stall_source, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready)
    // partial remainder stays below the divisor through the chain
    `ATFO_ASSERT_IMP(a_rem_first, i_clk, i_rst_n, v_chain[0] && d_chain[0].ramp, d_chain[0].rem < d_chain[0].frames)
    `ATFO_ASSERT_IMP(a_rem_last, i_clk, i_rst_n, v_chain[N] && d_chain[N].ramp, d_chain[N].rem < d_chain[N].frames)
    `ATFO_ASSERT_NXT(a_cfg_limit, i_clk, i_rst_n, i_cfg_we && (i_cfg_addr == atfo_pkg::CFG_FADE_LIMIT), r_fade_limit == $past(i_cfg_wdata[12:0]))

endmodule
